// ===== design/hppc_pkg.sv =====
// ----------------------------------------------------------------------------
// hppc_pkg
// Shared types, codes, constants and arithmetic helpers for the pose
// controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hppc_pkg;

   // Item kinds on the request channel.
   typedef enum logic [1:0] {
      REQ_TICK        = 2'd0,
      REQ_TICK_NOPOSE = 2'd1,
      REQ_GOAL        = 2'd2,
      REQ_PREEMPT     = 2'd3
   } req_kind_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_MOVING   = 3'd1,
      ST_REACHED  = 3'd2,
      ST_STALL    = 3'd3,
      ST_STOPPED  = 3'd4,
      ST_ACCEPTED = 3'd5
   } status_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_P_GAIN        = 3'd0;
   localparam logic [2:0] CSR_LIN_VEL_LIMIT = 3'd1;
   localparam logic [2:0] CSR_ANG_VEL_LIMIT = 3'd2;
   localparam logic [2:0] CSR_LIN_STEP      = 3'd3;
   localparam logic [2:0] CSR_ANG_STEP      = 3'd4;
   localparam logic [2:0] CSR_POS_TOL       = 3'd5;
   localparam logic [2:0] CSR_HEAD_TOL      = 3'd6;
   localparam logic [2:0] CSR_STALL_SPEED   = 3'd7;

   // Controller states.
   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_PREP, S_ROT, S_ROUND,
      S_MA, S_MB, S_MC, S_MD, S_ME, S_MF, S_MG, S_MH, S_MI, S_MJ,
      S_FIN, S_EMIT
   } state_type;

   // Multiply sequence step selected by the controller.
   typedef enum logic [3:0] {
      MS_NONE, MS_A, MS_B, MS_C, MS_D, MS_E, MS_F, MS_G, MS_H, MS_I, MS_J
   } mstep_type;

   typedef struct packed {
      logic       load_req;
      logic       load_goal;
      logic       clear_active;
      logic       set_status;
      status_type status;
      logic       prep;
      logic       rot_step;
      logic       round;
      mstep_type  mstep;
      logic       fin;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      req_kind_type req_kind;
      logic         goal_active;
      logic         rot_last;
   } sts_type;

   // Angles in Q3.13 and Q16.16.
   localparam logic signed [17:0] PI_Q      = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q  = 18'sd51472;
   localparam logic signed [23:0] HALF_PI_Z = 24'sd102944;
   localparam logic signed [23:0] PI_Z      = 24'sd205888;
   localparam logic signed [32:0] CORDIC_K  = 33'sd652032874;
   localparam logic [3:0]         SHIFT_LIN = 4'd12;
   localparam logic [3:0]         SHIFT_ANG = 4'd9;

   // Arctangent table, Q16.16 radians.
   function automatic logic [16:0] atan_q16(input logic [4:0] idx);
      logic [16:0] r;
      case (idx)
         5'd0:    r = 17'd51472;
         5'd1:    r = 17'd30386;
         5'd2:    r = 17'd16055;
         5'd3:    r = 17'd8150;
         5'd4:    r = 17'd4091;
         5'd5:    r = 17'd2047;
         5'd6:    r = 17'd1024;
         5'd7:    r = 17'd512;
         5'd8:    r = 17'd256;
         5'd9:    r = 17'd128;
         5'd10:   r = 17'd64;
         5'd11:   r = 17'd32;
         5'd12:   r = 17'd16;
         5'd13:   r = 17'd8;
         5'd14:   r = 17'd4;
         5'd15:   r = 17'd2;
         5'd16:   r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // One wrap step into [-pi, pi]; enough for every value used here.
   function automatic logic signed [17:0] wrap_pi(input logic signed [17:0] a);
      logic signed [17:0] r;
      r = a;
      if (a > PI_Q) begin
         r = a - TWO_PI_Q;
      end else if (a < -PI_Q) begin
         r = a + TWO_PI_Q;
      end
      return r;
   endfunction

   // Gain product to velocity: floor shift, speed clamp, then change limit.
   function automatic logic signed [15:0] vel_step(
      input logic signed [54:0] prod,
      input logic [3:0]         sh,
      input logic [14:0]        limit,
      input logic signed [15:0] old,
      input logic [14:0]        step);
      logic signed [54:0] v;
      logic signed [54:0] lim;
      logic signed [54:0] o;
      logic signed [54:0] s;
      v   = prod >>> sh;
      lim = $signed({40'd0, limit});
      o   = 55'(old);
      s   = $signed({40'd0, step});
      if (v > lim) begin
         v = lim;
      end
      if (v < -lim) begin
         v = -lim;
      end
      if (v > o + s) begin
         v = o + s;
      end
      if (v < o - s) begin
         v = o - s;
      end
      return v[15:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/holonomic_pose_p_controller.sv =====
// Every item but a tick with pose and an active goal goes from dispatch
// straight to emit; such a tick first passes through prep, the iterative
// CORDIC, rounding, ten passes through the one multiplier and fin. A new
// item is taken only in idle, after the last result has left emit.
// Synchronous reset restores register defaults, clears the goal and
// velocity state and drops the result valid.
// ----------------------------------------------------------------------------
// holonomic_pose_p_controller
// Proportional pose controller with slew limit for an omnidirectional base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module holonomic_pose_p_controller #(
   parameter int STALL_TICKS = 150,
   parameter int TRIG_STEPS  = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_wr_en,
   input  wire  [2:0]         csr_index,
   input  wire  [15:0]        csr_wdata,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [1:0]         req_type,
   input  wire  signed [31:0] req_pos_x,
   input  wire  signed [31:0] req_pos_y,
   input  wire  signed [15:0] req_heading,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [15:0] rsp_cmd_vx,
   output logic signed [15:0] rsp_cmd_vy,
   output logic signed [15:0] rsp_cmd_vth,
   output logic [2:0]         rsp_status
);

   hppc_pkg::cmd_type cmd;
   hppc_pkg::sts_type sts;

   // Sequencer.
   hppc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic and state.
   hppc_dp #(
      .STALL_TICKS (STALL_TICKS),
      .TRIG_STEPS  (TRIG_STEPS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_type    (req_type),
      .req_pos_x   (req_pos_x),
      .req_pos_y   (req_pos_y),
      .req_heading (req_heading),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_cmd_vx  (rsp_cmd_vx),
      .rsp_cmd_vy  (rsp_cmd_vy),
      .rsp_cmd_vth (rsp_cmd_vth),
      .rsp_status  (rsp_status)
   );

endmodule

`default_nettype wire

// ===== design/hppc_ctrl.sv =====
// ----------------------------------------------------------------------------
// hppc_ctrl
// Sequencer: accepts items, steps the datapath through the CORDIC and the
// shared multiplier, and owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hppc_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   input  hppc_pkg::sts_type     sts,
   output hppc_pkg::cmd_type     cmd
);

   hppc_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_busy;

   assign req_stall = (state_ff != hppc_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_busy  = rsp_valid_ff && rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hppc_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = hppc_pkg::S_DISPATCH;
            end
         end
         hppc_pkg::S_DISPATCH: begin
            if (sts.req_kind == hppc_pkg::REQ_TICK && sts.goal_active) begin
               state_in = hppc_pkg::S_PREP;
            end else begin
               state_in = hppc_pkg::S_EMIT;
            end
         end
         hppc_pkg::S_PREP:  state_in = hppc_pkg::S_ROT;
         hppc_pkg::S_ROT: begin
            if (sts.rot_last) begin
               state_in = hppc_pkg::S_ROUND;
            end
         end
         hppc_pkg::S_ROUND: state_in = hppc_pkg::S_MA;
         hppc_pkg::S_MA:    state_in = hppc_pkg::S_MB;
         hppc_pkg::S_MB:    state_in = hppc_pkg::S_MC;
         hppc_pkg::S_MC:    state_in = hppc_pkg::S_MD;
         hppc_pkg::S_MD:    state_in = hppc_pkg::S_ME;
         hppc_pkg::S_ME:    state_in = hppc_pkg::S_MF;
         hppc_pkg::S_MF:    state_in = hppc_pkg::S_MG;
         hppc_pkg::S_MG:    state_in = hppc_pkg::S_MH;
         hppc_pkg::S_MH:    state_in = hppc_pkg::S_MI;
         hppc_pkg::S_MI:    state_in = hppc_pkg::S_MJ;
         hppc_pkg::S_MJ:    state_in = hppc_pkg::S_FIN;
         hppc_pkg::S_FIN:   state_in = hppc_pkg::S_EMIT;
         hppc_pkg::S_EMIT: begin
            if (!out_busy) begin
               state_in = hppc_pkg::S_IDLE;
            end
         end
         default: state_in = hppc_pkg::S_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd          = '0;
      cmd.status   = hppc_pkg::ST_IDLE;
      cmd.mstep    = hppc_pkg::MS_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         hppc_pkg::S_IDLE: begin
            cmd.load_req = req_valid;
         end
         hppc_pkg::S_DISPATCH: begin
            case (sts.req_kind)
               hppc_pkg::REQ_GOAL: begin
                  cmd.load_goal  = 1'b1;
                  cmd.set_status = 1'b1;
                  cmd.status     = hppc_pkg::ST_ACCEPTED;
               end
               hppc_pkg::REQ_PREEMPT: begin
                  cmd.clear_active = 1'b1;
                  cmd.set_status   = 1'b1;
                  cmd.status       = hppc_pkg::ST_STOPPED;
               end
               default: begin
                  if (!sts.goal_active) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = hppc_pkg::ST_IDLE;
                  end else if (sts.req_kind == hppc_pkg::REQ_TICK_NOPOSE) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = hppc_pkg::ST_STOPPED;
                  end
               end
            endcase
         end
         hppc_pkg::S_PREP:  cmd.prep     = 1'b1;
         hppc_pkg::S_ROT:   cmd.rot_step = 1'b1;
         hppc_pkg::S_ROUND: cmd.round    = 1'b1;
         hppc_pkg::S_MA:    cmd.mstep    = hppc_pkg::MS_A;
         hppc_pkg::S_MB:    cmd.mstep    = hppc_pkg::MS_B;
         hppc_pkg::S_MC:    cmd.mstep    = hppc_pkg::MS_C;
         hppc_pkg::S_MD:    cmd.mstep    = hppc_pkg::MS_D;
         hppc_pkg::S_ME:    cmd.mstep    = hppc_pkg::MS_E;
         hppc_pkg::S_MF:    cmd.mstep    = hppc_pkg::MS_F;
         hppc_pkg::S_MG:    cmd.mstep    = hppc_pkg::MS_G;
         hppc_pkg::S_MH:    cmd.mstep    = hppc_pkg::MS_H;
         hppc_pkg::S_MI:    cmd.mstep    = hppc_pkg::MS_I;
         hppc_pkg::S_MJ:    cmd.mstep    = hppc_pkg::MS_J;
         hppc_pkg::S_FIN:   cmd.fin      = 1'b1;
         hppc_pkg::S_EMIT: begin
            if (!out_busy) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hppc_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted request always goes to dispatch next.
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == hppc_pkg::S_DISPATCH))
      else $error("accepted request did not reach dispatch");

   // Rounding only follows the last rotation step.
   a_round_after_rot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hppc_pkg::S_ROUND) |-> ($past(state_ff) == hppc_pkg::S_ROT))
      else $error("rounding entered without rotation");

   // A result leaving the emit state is presented on the next cycle.
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hppc_pkg::S_EMIT && !out_busy) |=> rsp_valid_ff)
      else $error("emitted result not valid");

endmodule

`default_nettype wire

// ===== design/hppc_dp.sv =====
// ----------------------------------------------------------------------------
// hppc_dp
// Datapath: configuration registers, goal and velocity state, CORDIC
// rotator, one shared multiplier and the result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hppc_dp #(
   parameter int STALL_TICKS = 150,
   parameter int TRIG_STEPS  = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_wr_en,
   input  wire  [2:0]          csr_index,
   input  wire  [15:0]         csr_wdata,
   input  wire  [1:0]          req_type,
   input  wire  signed [31:0]  req_pos_x,
   input  wire  signed [31:0]  req_pos_y,
   input  wire  signed [15:0]  req_heading,
   input  hppc_pkg::cmd_type   cmd,
   output hppc_pkg::sts_type   sts,
   output logic signed [15:0]  rsp_cmd_vx,
   output logic signed [15:0]  rsp_cmd_vy,
   output logic signed [15:0]  rsp_cmd_vth,
   output logic [2:0]          rsp_status
);

   localparam int CW = $clog2(TRIG_STEPS);

   // Configuration.
   logic [15:0] p_gain_ff;
   logic [14:0] lin_lim_ff, ang_lim_ff, lin_step_ff, ang_step_ff;
   logic [15:0] pos_tol_ff;
   logic [14:0] head_tol_ff, stall_ff;

   // Latched request.
   hppc_pkg::req_kind_type kind_ff;
   logic signed [31:0] px_ff, py_ff;
   logic signed [15:0] ph_ff;

   // Controller state.
   logic signed [31:0] goal_x_ff, goal_y_ff;
   logic signed [15:0] goal_yaw_ff;
   logic               active_ff;
   logic signed [15:0] last_vx_ff, last_vy_ff, last_vth_ff;
   logic [15:0]        slow_ff;

   // Working registers.
   logic signed [32:0] ex_ff, ey_ff;
   logic signed [16:0] eth_ff;
   logic               reached_ff;
   logic signed [32:0] cx_ff, cy_ff;
   logic signed [23:0] cz_ff;
   logic               neg_ff;
   logic [CW-1:0]      cnt_ff;
   logic signed [16:0] c_ff, s_ff;
   logic signed [54:0] prod_ff;
   logic signed [55:0] acc_ff;
   logic signed [36:0] dx_ff, dy_ff;
   logic signed [15:0] vxn_ff, vyn_ff, vthn_ff;

   // Pending result.
   logic signed [15:0] res_vx_ff, res_vy_ff, res_vth_ff;
   hppc_pkg::status_type res_st_ff;

   // Preparation logic: errors, tolerance check, CORDIC angle fold.
   logic signed [17:0] ph_w, gy_w, d_eth, d_head;
   logic signed [32:0] dpx, dpy, tol;
   logic signed [23:0] z8;
   logic               in_tol;

   always_comb begin
      ph_w  = hppc_pkg::wrap_pi(18'(ph_ff));
      gy_w  = hppc_pkg::wrap_pi(18'(goal_yaw_ff));
      d_eth = 18'(goal_yaw_ff) - 18'(ph_ff);
      if (d_eth >= hppc_pkg::TWO_PI_Q) begin
         d_eth = d_eth - hppc_pkg::TWO_PI_Q;
      end else if (d_eth <= -hppc_pkg::TWO_PI_Q) begin
         d_eth = d_eth + hppc_pkg::TWO_PI_Q;
      end
      d_eth  = hppc_pkg::wrap_pi(d_eth);
      d_head = hppc_pkg::wrap_pi(ph_w - gy_w);
      dpx    = 33'(px_ff) - 33'(goal_x_ff);
      dpy    = 33'(py_ff) - 33'(goal_y_ff);
      tol    = $signed({17'd0, pos_tol_ff});
      in_tol = (dpx <= tol) && (dpx >= -tol) && (dpy <= tol) && (dpy >= -tol) &&
               (d_head <= $signed({3'd0, head_tol_ff})) &&
               (d_head >= -$signed({3'd0, head_tol_ff}));
      z8     = 24'(ph_w) <<< 3;
   end

   // CORDIC step.
   logic signed [32:0] xs, ys, xneg, yneg;
   logic signed [33:0] xr, yr;
   logic signed [23:0] at;

   always_comb begin
      xs   = cx_ff >>> cnt_ff;
      ys   = cy_ff >>> cnt_ff;
      at   = $signed({7'd0, hppc_pkg::atan_q16(5'(cnt_ff))});
      xneg = neg_ff ? -cx_ff : cx_ff;
      yneg = neg_ff ? -cy_ff : cy_ff;
      xr   = (34'(xneg) + 34'sd16384) >>> 15;
      yr   = (34'(yneg) + 34'sd16384) >>> 15;
   end

   // Shared multiplier operand select.
   logic signed [36:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [17:0] gain_s;

   always_comb begin
      gain_s = $signed({2'd0, p_gain_ff});
      mul_a  = '0;
      mul_b  = '0;
      case (cmd.mstep)
         hppc_pkg::MS_A: begin mul_a = 37'(ex_ff);   mul_b = 18'(c_ff); end
         hppc_pkg::MS_B: begin mul_a = 37'(ey_ff);   mul_b = 18'(s_ff); end
         hppc_pkg::MS_C: begin mul_a = 37'(ey_ff);   mul_b = 18'(c_ff); end
         hppc_pkg::MS_D: begin mul_a = 37'(ex_ff);   mul_b = 18'(s_ff); end
         hppc_pkg::MS_E: begin mul_a = dx_ff;        mul_b = gain_s;    end
         hppc_pkg::MS_F: begin mul_a = dy_ff;        mul_b = gain_s;    end
         hppc_pkg::MS_G: begin mul_a = 37'(eth_ff);  mul_b = gain_s;    end
         hppc_pkg::MS_H: begin mul_a = 37'(vxn_ff);  mul_b = 18'(vxn_ff); end
         hppc_pkg::MS_I: begin mul_a = 37'(vyn_ff);  mul_b = 18'(vyn_ff); end
         hppc_pkg::MS_J: begin
            mul_a = $signed({22'd0, stall_ff});
            mul_b = $signed({3'd0, stall_ff});
         end
         default: begin
         end
      endcase
   end

   // Slow-tick decision at the end of a tick.
   logic slow;
   assign slow = (acc_ff < 56'(prod_ff)) && (vthn_ff < $signed({1'b0, stall_ff}));

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_gain_ff   <= 16'd307;
         lin_lim_ff  <= 15'd819;
         ang_lim_ff  <= 15'd819;
         lin_step_ff <= 15'd55;
         ang_step_ff <= 15'd55;
         pos_tol_ff  <= 16'd328;
         head_tol_ff <= 15'd41;
         stall_ff    <= 15'd82;
      end else if (csr_wr_en) begin
         case (csr_index)
            hppc_pkg::CSR_P_GAIN:        p_gain_ff   <= csr_wdata;
            hppc_pkg::CSR_LIN_VEL_LIMIT: lin_lim_ff  <= csr_wdata[14:0];
            hppc_pkg::CSR_ANG_VEL_LIMIT: ang_lim_ff  <= csr_wdata[14:0];
            hppc_pkg::CSR_LIN_STEP:      lin_step_ff <= csr_wdata[14:0];
            hppc_pkg::CSR_ANG_STEP:      ang_step_ff <= csr_wdata[14:0];
            hppc_pkg::CSR_POS_TOL:       pos_tol_ff  <= csr_wdata;
            hppc_pkg::CSR_HEAD_TOL:      head_tol_ff <= csr_wdata[14:0];
            hppc_pkg::CSR_STALL_SPEED:   stall_ff    <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // Goal, activity and velocity history.
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff   <= '0;
         goal_y_ff   <= '0;
         goal_yaw_ff <= '0;
         active_ff   <= 1'b0;
         last_vx_ff  <= '0;
         last_vy_ff  <= '0;
         last_vth_ff <= '0;
         slow_ff     <= '0;
      end else begin
         if (cmd.load_goal) begin
            goal_x_ff   <= px_ff;
            goal_y_ff   <= py_ff;
            goal_yaw_ff <= ph_ff;
            slow_ff     <= '0;
            active_ff   <= 1'b1;
         end
         if (cmd.clear_active) begin
            active_ff <= 1'b0;
         end
         if (cmd.fin) begin
            last_vx_ff  <= vxn_ff;
            last_vy_ff  <= vyn_ff;
            last_vth_ff <= vthn_ff;
            if (reached_ff) begin
               active_ff <= 1'b0;
            end else if (slow) begin
               if (slow_ff >= 16'(STALL_TICKS)) begin
                  active_ff <= 1'b0;
               end else begin
                  slow_ff <= slow_ff + 16'd1;
               end
            end else begin
               slow_ff <= '0;
            end
         end
      end
   end

   // CORDIC step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.prep) begin
         cnt_ff <= '0;
      end else if (cmd.rot_step) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
   end

   // Working datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.load_req) begin
         kind_ff <= hppc_pkg::req_kind_type'(req_type);
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         ph_ff   <= req_heading;
      end
      if (cmd.prep) begin
         ex_ff      <= 33'(goal_x_ff) - 33'(px_ff);
         ey_ff      <= 33'(goal_y_ff) - 33'(py_ff);
         eth_ff     <= 17'(d_eth);
         reached_ff <= in_tol;
         cx_ff      <= hppc_pkg::CORDIC_K;
         cy_ff      <= '0;
         if (z8 > hppc_pkg::HALF_PI_Z) begin
            cz_ff  <= z8 - hppc_pkg::PI_Z;
            neg_ff <= 1'b1;
         end else if (z8 < -hppc_pkg::HALF_PI_Z) begin
            cz_ff  <= z8 + hppc_pkg::PI_Z;
            neg_ff <= 1'b1;
         end else begin
            cz_ff  <= z8;
            neg_ff <= 1'b0;
         end
      end
      if (cmd.rot_step) begin
         if (cz_ff >= 0) begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - at;
         end else begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + at;
         end
      end
      if (cmd.round) begin
         c_ff <= 17'(xr);
         s_ff <= 17'(yr);
      end
      // Consume the product registered in the previous step.
      case (cmd.mstep)
         hppc_pkg::MS_B: acc_ff <= 56'(prod_ff);
         hppc_pkg::MS_C: dx_ff  <= 37'((acc_ff + 56'(prod_ff)) >>> 15);
         hppc_pkg::MS_D: acc_ff <= 56'(prod_ff);
         hppc_pkg::MS_E: dy_ff  <= 37'((acc_ff - 56'(prod_ff)) >>> 15);
         hppc_pkg::MS_F: vxn_ff <= hppc_pkg::vel_step(prod_ff, hppc_pkg::SHIFT_LIN,
                                      lin_lim_ff, last_vx_ff, lin_step_ff);
         hppc_pkg::MS_G: vyn_ff <= hppc_pkg::vel_step(prod_ff, hppc_pkg::SHIFT_LIN,
                                      lin_lim_ff, last_vy_ff, lin_step_ff);
         hppc_pkg::MS_H: vthn_ff <= hppc_pkg::vel_step(prod_ff, hppc_pkg::SHIFT_ANG,
                                       ang_lim_ff, last_vth_ff, ang_step_ff);
         hppc_pkg::MS_I: acc_ff <= 56'(prod_ff);
         hppc_pkg::MS_J: acc_ff <= acc_ff + 56'(prod_ff);
         default: begin
         end
      endcase
      // Pending result.
      if (cmd.set_status) begin
         res_st_ff  <= cmd.status;
         res_vx_ff  <= '0;
         res_vy_ff  <= '0;
         res_vth_ff <= '0;
      end
      if (cmd.fin) begin
         res_vx_ff  <= '0;
         res_vy_ff  <= '0;
         res_vth_ff <= '0;
         if (reached_ff) begin
            res_st_ff <= hppc_pkg::ST_REACHED;
         end else if (slow && slow_ff >= 16'(STALL_TICKS)) begin
            res_st_ff <= hppc_pkg::ST_STALL;
         end else begin
            res_st_ff  <= hppc_pkg::ST_MOVING;
            res_vx_ff  <= vxn_ff;
            res_vy_ff  <= vyn_ff;
            res_vth_ff <= vthn_ff;
         end
      end
      if (cmd.emit) begin
         rsp_cmd_vx  <= res_vx_ff;
         rsp_cmd_vy  <= res_vy_ff;
         rsp_cmd_vth <= res_vth_ff;
         rsp_status  <= res_st_ff;
      end
   end

   assign sts.req_kind    = kind_ff;
   assign sts.goal_active = active_ff;
   assign sts.rot_last    = (cnt_ff == CW'(TRIG_STEPS - 1));

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the holonomic pose controller. A behavioral model
// of the controller predicts one result per request. Each result is checked
// field by field against the oldest prediction while both channels idle and
// stall at random. Register settings are changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

   localparam int    STALL_TICKS = 150;
   localparam int    TRIG_STEPS  = 16;
   localparam int    WATCHDOG    = 4000;
   localparam longint PI_A       = 25736;
   localparam longint TWO_PI_A   = 51472;

   typedef struct {
      logic signed [15:0]   vx;
      logic signed [15:0]   vy;
      logic signed [15:0]   vth;
      hppc_pkg::status_type st;
   } motion_cmd_type;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [2:0]         csr_index;
   logic [15:0]        csr_wdata;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_type;
   logic signed [31:0] req_pos_x;
   logic signed [31:0] req_pos_y;
   logic signed [15:0] req_heading;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_cmd_vx;
   logic signed [15:0] rsp_cmd_vy;
   logic signed [15:0] rsp_cmd_vth;
   logic [2:0]         rsp_status;

   holonomic_pose_p_controller #(
      .STALL_TICKS(STALL_TICKS),
      .TRIG_STEPS (TRIG_STEPS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_type   (req_type),
      .req_pos_x  (req_pos_x),
      .req_pos_y  (req_pos_y),
      .req_heading(req_heading),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_cmd_vx (rsp_cmd_vx),
      .rsp_cmd_vy (rsp_cmd_vy),
      .rsp_cmd_vth(rsp_cmd_vth),
      .rsp_status (rsp_status)
   );

   // Predicted commands, oldest first.
   motion_cmd_type pending_cmds[$];
   int        error_count;
   int        quiet_cycles;
   int        burst_left;

   // Controller model: registers and state.
   longint    gain_reg, lin_lim_reg, ang_lim_reg, lin_step_reg, ang_step_reg;
   longint    pos_tol_reg, head_tol_reg, stall_spd_reg;
   longint    tgt_x, tgt_y, tgt_yaw;
   bit        tgt_on;
   longint    prev_vx, prev_vy, prev_vth;
   int        slow_count;

   // Clock generation.
   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic longint wrap_angle(input longint a);
      longint r;
      r = a;
      while (r > PI_A) r -= TWO_PI_A;
      while (r < -PI_A) r += TWO_PI_A;
      return r;
   endfunction

   // Iterative rotation giving cosine and sine of a heading, in Q15.
   function automatic void heading_sincos(input longint h, output longint c,
                                          output longint s);
      longint z, x, y, nx, ang;
      bit     flip;
      z = wrap_angle(h) * 8;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (z > (PI_A * 8) / 2) begin
         z -= PI_A * 8;
         flip = 1'b1;
      end else if (z < -(PI_A * 8) / 2) begin
         z += PI_A * 8;
         flip = 1'b1;
      end
      for (int i = 0; i < TRIG_STEPS && i < 24; i++) begin
         ang = longint'(hppc_pkg::atan_q16(5'(i)));
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= ang;
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += ang;
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = (x + 16384) >>> 15;
      s = (y + 16384) >>> 15;
   endfunction

   // Gain, speed clamp, then change limit against the previous command.
   function automatic longint limited_vel(input longint err, input int sh,
                                          input longint lim, input longint old,
                                          input longint step);
      longint v;
      v = (gain_reg * err) >>> sh;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      if (v > old + step) v = old + step;
      if (v < old - step) v = old - step;
      return v;
   endfunction

   function automatic motion_cmd_type stop_cmd(input hppc_pkg::status_type st);
      motion_cmd_type m;
      m.vx = '0;
      m.vy = '0;
      m.vth = '0;
      m.st = st;
      return m;
   endfunction

   // Advance the controller model by one request and return its command.
   function automatic motion_cmd_type predict_motion(input logic [1:0] kind,
                                                     input longint px, input longint py,
                                                     input longint ph);
      longint    ex, ey, eth, c, s, dx, dy, vx, vy, vth;
      motion_cmd_type m;
      if (kind == hppc_pkg::REQ_GOAL) begin
         tgt_x = px;
         tgt_y = py;
         tgt_yaw = ph;
         slow_count = 0;
         tgt_on = 1'b1;
         return stop_cmd(hppc_pkg::ST_ACCEPTED);
      end
      if (kind == hppc_pkg::REQ_PREEMPT) begin
         tgt_on = 1'b0;
         return stop_cmd(hppc_pkg::ST_STOPPED);
      end
      if (!tgt_on) return stop_cmd(hppc_pkg::ST_IDLE);
      if (kind == hppc_pkg::REQ_TICK_NOPOSE) return stop_cmd(hppc_pkg::ST_STOPPED);

      ex = tgt_x - px;
      ey = tgt_y - py;
      eth = tgt_yaw - ph;
      if (eth >= TWO_PI_A) eth -= TWO_PI_A;
      else if (eth <= -TWO_PI_A) eth += TWO_PI_A;
      eth = wrap_angle(eth);
      heading_sincos(ph, c, s);
      dx = (ex * c + ey * s) >>> 15;
      dy = (ey * c - ex * s) >>> 15;
      vx = limited_vel(dx, 12, lin_lim_reg, prev_vx, lin_step_reg);
      vy = limited_vel(dy, 12, lin_lim_reg, prev_vy, lin_step_reg);
      vth = limited_vel(eth, 9, ang_lim_reg, prev_vth, ang_step_reg);
      prev_vx = vx;
      prev_vy = vy;
      prev_vth = vth;

      // Goal reached: all three tolerances hold.
      eth = wrap_angle(wrap_angle(ph) - wrap_angle(tgt_yaw));
      if ((px - tgt_x <= pos_tol_reg) && (tgt_x - px <= pos_tol_reg) &&
          (py - tgt_y <= pos_tol_reg) && (tgt_y - py <= pos_tol_reg) &&
          (eth <= head_tol_reg) && (-eth <= head_tol_reg)) begin
         tgt_on = 1'b0;
         return stop_cmd(hppc_pkg::ST_REACHED);
      end

      // Stall detection on slow ticks.
      if ((vx * vx + vy * vy < stall_spd_reg * stall_spd_reg) &&
          (vth < stall_spd_reg)) begin
         if (slow_count >= STALL_TICKS) begin
            tgt_on = 1'b0;
            return stop_cmd(hppc_pkg::ST_STALL);
         end
         slow_count++;
      end else begin
         slow_count = 0;
      end
      m.vx = vx[15:0];
      m.vy = vy[15:0];
      m.vth = vth[15:0];
      m.st = hppc_pkg::ST_MOVING;
      return m;
   endfunction

   // Send one request, pausing between bursts, and record its prediction.
   task automatic send_request(input logic [1:0] kind, input logic [31:0] px,
                               input logic [31:0] py, input logic [15:0] ph);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_pos_x   <= px;
      req_pos_y   <= py;
      req_heading <= ph;
      do @(posedge clock); while (req_stall);
      pending_cmds.push_back(predict_motion(kind, longint'($signed(px)),
                                            longint'($signed(py)),
                                            longint'($signed(ph))));
   endtask

   // Wait for the block to drain, then write one register.
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         hppc_pkg::CSR_P_GAIN:        gain_reg = val;
         hppc_pkg::CSR_LIN_VEL_LIMIT: lin_lim_reg = val[14:0];
         hppc_pkg::CSR_ANG_VEL_LIMIT: ang_lim_reg = val[14:0];
         hppc_pkg::CSR_LIN_STEP:      lin_step_reg = val[14:0];
         hppc_pkg::CSR_ANG_STEP:      ang_step_reg = val[14:0];
         hppc_pkg::CSR_POS_TOL:       pos_tol_reg = val;
         hppc_pkg::CSR_HEAD_TOL:      head_tol_reg = val[14:0];
         hppc_pkg::CSR_STALL_SPEED:   stall_spd_reg = val[14:0];
         default:                     ;
      endcase
   endtask

   task automatic write_all_regs(input logic [15:0] g, input logic [15:0] lv,
                                 input logic [15:0] av, input logic [15:0] ls,
                                 input logic [15:0] as, input logic [15:0] pt,
                                 input logic [15:0] ht, input logic [15:0] ss);
      write_reg(hppc_pkg::CSR_P_GAIN, g);
      write_reg(hppc_pkg::CSR_LIN_VEL_LIMIT, lv);
      write_reg(hppc_pkg::CSR_ANG_VEL_LIMIT, av);
      write_reg(hppc_pkg::CSR_LIN_STEP, ls);
      write_reg(hppc_pkg::CSR_ANG_STEP, as);
      write_reg(hppc_pkg::CSR_POS_TOL, pt);
      write_reg(hppc_pkg::CSR_HEAD_TOL, ht);
      write_reg(hppc_pkg::CSR_STALL_SPEED, ss);
   endtask

   function automatic logic [15:0] any_heading();
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(0, 51472)) - 25736);
   endfunction

   // Every request kind, idle handling and field extremes.
   task automatic test_request_kinds();
      send_request(hppc_pkg::REQ_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd25736);
      send_request(hppc_pkg::REQ_TICK_NOPOSE, 0, 0, 0);
      send_request(hppc_pkg::REQ_PREEMPT, 0, 0, 0);
      send_request(hppc_pkg::REQ_GOAL, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd25736);
      send_request(hppc_pkg::REQ_TICK, 32'h8000_0000, 32'h7FFF_FFFF, -16'sd25736);
      send_request(hppc_pkg::REQ_TICK_NOPOSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(hppc_pkg::REQ_TICK, 0, 0, 16'h7FFF);
      send_request(hppc_pkg::REQ_TICK, 0, 0, 16'h8000);
      send_request(hppc_pkg::REQ_PREEMPT, 0, 0, 0);
      send_request(hppc_pkg::REQ_TICK, 0, 0, 0);
      // Goal near pi with a tick just across the wrap, then a goal heading outside pi.
      send_request(hppc_pkg::REQ_GOAL, 32'sd1000, -32'sd2000, 16'sd25700);
      send_request(hppc_pkg::REQ_TICK, 32'sd1100, -32'sd1900, -16'sd25730);
      send_request(hppc_pkg::REQ_GOAL, 0, 0, 16'h8000);
      send_request(hppc_pkg::REQ_TICK, 0, 0, 16'sd19208);
      send_request(hppc_pkg::REQ_GOAL, 32'sd65536, 32'sd65536, 16'sd0);
      send_request(hppc_pkg::REQ_TICK, 0, 0, 16'sd12868);
      send_request(hppc_pkg::REQ_TICK, 0, 0, -16'sd12868);
      send_request(hppc_pkg::REQ_TICK, 32'sd131072, 32'sd131072, 16'sd30000);
      send_request(hppc_pkg::REQ_TICK_NOPOSE, 0, 0, 0);
      send_request(hppc_pkg::REQ_PREEMPT, 0, 0, 0);
   endtask

   // Slow motion long enough to trip the stall abort.
   task automatic test_stall_abort();
      write_reg(hppc_pkg::CSR_STALL_SPEED, 16'h7FFF);
      send_request(hppc_pkg::REQ_GOAL, 32'sd6553600, -32'sd3276800, 16'sd5000);
      repeat (STALL_TICKS + 3) send_request(hppc_pkg::REQ_TICK, 0, 0, 0);
      write_reg(hppc_pkg::CSR_STALL_SPEED, 16'd82);
   endtask

   // Goal approach: ticks that converge on the goal, with some noise.
   task automatic run_approach();
      longint gx, gy, cx, cy, ch, gh;
      int     n;
      gx = longint'($signed(32'($urandom)));
      gy = longint'($signed(32'($urandom)));
      if ($urandom_range(0, 2) != 0) begin
         gx = gx >>> $urandom_range(8, 28);
         gy = gy >>> $urandom_range(8, 28);
      end
      gh = longint'($signed(any_heading()));
      send_request(hppc_pkg::REQ_GOAL, 32'(gx), 32'(gy), 16'(gh));
      cx = gx + $signed($urandom_range(0, 400000)) - 200000;
      cy = gy + $signed($urandom_range(0, 400000)) - 200000;
      ch = longint'($signed(any_heading()));
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0:       send_request(hppc_pkg::REQ_TICK_NOPOSE, $urandom, $urandom,
                                  16'($urandom));
            1:       send_request(hppc_pkg::REQ_PREEMPT, $urandom, $urandom,
                                  16'($urandom));
            2:       send_request(hppc_pkg::REQ_TICK, $urandom, $urandom,
                                  16'($urandom));
            default: send_request(hppc_pkg::REQ_TICK, 32'(cx), 32'(cy), 16'(ch));
         endcase
         cx = cx + (gx - cx) / 2;
         cy = cy + (gy - cy) / 2;
         ch = ch + (gh - ch) / 2;
      end
   endtask

   task automatic test_random_traffic(input int items);
      for (int i = 0; i < items; i += 10) begin
         if ($urandom_range(0, 4) == 0)
            send_request(2'($urandom), $urandom, $urandom, 16'($urandom));
         else
            run_approach();
      end
   endtask

   // Several register settings, extremes included.
   task automatic test_register_sweep();
      write_all_regs(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                     16'hFFFF, 16'h7FFF, 16'h7FFF);
      test_random_traffic(150);
      write_all_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      test_random_traffic(100);
      write_all_regs(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'd3000, 16'd3000,
                     16'd0, 16'd0, 16'd0);
      test_random_traffic(150);
      for (int k = 0; k < 3; k++) begin
         write_all_regs(16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                        16'($urandom), 16'($urandom), 16'($urandom_range(0, 1000)));
         test_random_traffic(200);
      end
      write_all_regs(16'd307, 16'd819, 16'd819, 16'd55, 16'd55,
                     16'd328, 16'd41, 16'd82);
   endtask

   // Receiver stall pattern: cycling through free, light, heavy and periodic stretches.
   always @(posedge clock) begin
      int cyc;
      cyc = $urandom_range(0, 99);
      case (($time / 400) % 4)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= (cyc < 25);
         2:       rsp_stall <= (cyc < 75);
         default: rsp_stall <= ((($time / 4) % 8) < 3);
      endcase
   end

   // Result checking against the oldest prediction.
   always @(posedge clock) begin
      motion_cmd_type exp_cmd;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmds.size() == 0) begin
            $error("result with no prediction waiting");
            error_count++;
         end else begin
            exp_cmd = pending_cmds.pop_front();
            if (rsp_cmd_vx !== exp_cmd.vx) begin
               $error("cmd_vx expected %0d actual %0d", exp_cmd.vx, rsp_cmd_vx);
               error_count++;
            end
            if (rsp_cmd_vy !== exp_cmd.vy) begin
               $error("cmd_vy expected %0d actual %0d", exp_cmd.vy, rsp_cmd_vy);
               error_count++;
            end
            if (rsp_cmd_vth !== exp_cmd.vth) begin
               $error("cmd_vth expected %0d actual %0d", exp_cmd.vth, rsp_cmd_vth);
               error_count++;
            end
            if (rsp_status !== exp_cmd.st) begin
               $error("status expected %0d actual %0d", exp_cmd.st, rsp_status);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en ||
          reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_type = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_heading = '0;
      rsp_stall = 1'b0;
      error_count = 0;
      quiet_cycles = 0;
      burst_left = 0;
      gain_reg = 307;
      lin_lim_reg = 819;
      ang_lim_reg = 819;
      lin_step_reg = 55;
      ang_step_reg = 55;
      pos_tol_reg = 328;
      head_tol_reg = 41;
      stall_spd_reg = 82;
      tgt_x = 0;
      tgt_y = 0;
      tgt_yaw = 0;
      tgt_on = 1'b0;
      prev_vx = 0;
      prev_vy = 0;
      prev_vth = 0;
      slow_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_request_kinds();
      test_random_traffic(500);
      test_stall_abort();
      test_register_sweep();
      test_random_traffic(150);

      req_valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
